@@ design/wwcf_pkg.sv @@
package wwcf_pkg;

   // Sizing of the block.
   localparam int MAX_WORDS    = 7;
   localparam int MAX_WORD_LEN = 8;
   localparam int COUNT_WIDTH  = 16;

   // Fixed field widths of the channels.
   localparam int BYTE_W     = 8;
   localparam int REG_BYTES  = 8;
   localparam int REG_W      = REG_BYTES * BYTE_W;
   localparam int HIT_W      = 16;
   localparam int IDX_W      = 3;
   localparam int WIU_W      = 3;
   localparam int CSR_IDX_W  = 3;

   // Derived widths.
   localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
   localparam int BSEL_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int SEL_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int RCNT_W = $clog2(MAX_WORDS + 1);
   localparam int ZPOS_W = $clog2(REG_BYTES + 1);
   localparam int SEQ_W  = $clog2(MAX_WORD_LEN + MAX_WORDS + 1);
   localparam int TOT_W  = SEQ_W + 1;

   // Job queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Command and result codes.
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_END     = 1'b1;
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Characters.
   localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WORDS_IN_USE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BANNED_BASE  = 3'd1;

   typedef struct packed {
      logic [WIU_W-1:0]                  words_in_use;
      logic [MAX_WORDS-1:0][REG_W-1:0]   banned;
   } cfg_type;

   // One unit of work for the back: an optional word, an optional trailing
   // character and an optional run of counter reports.
   typedef struct packed {
      logic [MAX_WORD_LEN-1:0][BYTE_W-1:0] word;
      logic [LEN_W-1:0]                    len;
      logic                                masked;
      logic                                has_char;
      logic [BYTE_W-1:0]                   tail_byte;
      logic [RCNT_W-1:0]                   report_count;
      logic [MAX_WORDS-1:0][HIT_W-1:0]     counts;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Length of a banned word: position of its first zero byte.
   function automatic logic [ZPOS_W-1:0] first_zero(input logic [REG_W-1:0] w);
      logic [ZPOS_W-1:0] pos;
      logic              found;
      pos   = ZPOS_W'(REG_BYTES);
      found = 1'b0;
      for (int b = 0; b < REG_BYTES; b++) begin
         if (!found && (w[b*BYTE_W +: BYTE_W] == CH_NUL)) begin
            pos   = ZPOS_W'(b);
            found = 1'b1;
         end
      end
      return pos;
   endfunction

endpackage

@@ design/wwcf_channels.sv @@
interface wwcf_req_if;
   import wwcf_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BYTE_W-1:0] msg_byte;
   modport source (output valid, cmd, msg_byte, input ready);
   modport sink   (input valid, cmd, msg_byte, output ready);
endinterface

interface wwcf_rsp_if;
   import wwcf_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] out_byte;
   logic [IDX_W-1:0]  word_index;
   logic [HIT_W-1:0]  hit_count;
   logic              last;
   modport source (output valid, kind, out_byte, word_index, hit_count, last, input ready);
   modport sink   (input valid, kind, out_byte, word_index, hit_count, last, output ready);
endinterface

interface wwcf_csr_if;
   import wwcf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [REG_W-1:0]     wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ design/wwcf_front.sv @@
module wwcf_front (
   input  logic                clock,
   input  logic                reset,
   wwcf_req_if.sink            req_if,
   input  wwcf_pkg::cfg_type   cfg,
   input  wwcf_pkg::qstat_type qstat,
   output logic                push,
   output wwcf_pkg::job_type   push_job
);
   import wwcf_pkg::*;

   logic [BYTE_W-1:0]      store_ff [MAX_WORD_LEN];
   logic [BYTE_W-1:0]      store_in [MAX_WORD_LEN];
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic [COUNT_WIDTH-1:0] cnt_ff [MAX_WORDS];
   logic [COUNT_WIDTH-1:0] cnt_in [MAX_WORDS];
   logic [COUNT_WIDTH-1:0] cnt_bump [MAX_WORDS];

   logic                   fire;
   logic                   is_end;
   logic                   is_space;
   logic                   release_word;
   logic [WIU_W-1:0]       active;
   logic [MAX_WORDS-1:0]   hit_vec;
   logic                   hit_any;
   logic [SEL_W-1:0]       hit_sel;

   assign req_if.ready = !qstat.full;
   assign fire         = req_if.valid && req_if.ready;
   assign is_end       = (req_if.cmd == CMD_END);
   assign is_space     = (req_if.cmd == CMD_BYTE) && (req_if.msg_byte == CH_SPACE);
   assign release_word = fire && (is_end || is_space);
   assign active       = (cfg.words_in_use > WIU_W'(MAX_WORDS)) ?
                         WIU_W'(MAX_WORDS) : cfg.words_in_use;

   // Whole-word compare against every active banned word in parallel.
   always_comb begin
      logic eq;
      for (int i = 0; i < MAX_WORDS; i++) begin
         eq = 1'b1;
         for (int b = 0; b < MAX_WORD_LEN; b++) begin
            if ((b < int'(len_ff)) &&
                (cfg.banned[i][b*BYTE_W +: BYTE_W] != store_ff[b])) begin
               eq = 1'b0;
            end
         end
         hit_vec[i] = (i < int'(active)) && (len_ff != '0) && eq &&
                      (int'(first_zero(cfg.banned[i])) == int'(len_ff));
      end
   end

   // The lowest-indexed hit wins.
   always_comb begin
      hit_sel = '0;
      for (int i = MAX_WORDS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_sel = SEL_W'(i);
         end
      end
   end
   assign hit_any = |hit_vec;

   always_comb begin
      for (int i = 0; i < MAX_WORDS; i++) begin
         cnt_bump[i] = cnt_ff[i];
         if (release_word && hit_any && (int'(hit_sel) == i) && (cnt_ff[i] != '1)) begin
            cnt_bump[i] = cnt_ff[i] + COUNT_WIDTH'(1);
         end
      end
   end

   always_comb begin
      store_in = store_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      for (int b = 0; b < MAX_WORD_LEN; b++) begin
         push_job.word[b] = store_ff[b];
      end
      for (int i = 0; i < MAX_WORDS; i++) begin
         push_job.counts[i] = HIT_W'(cnt_bump[i]);
      end
      push_job.len          = len_ff;
      push_job.masked       = 1'b0;
      push_job.has_char     = 1'b0;
      push_job.tail_byte    = req_if.msg_byte;
      push_job.report_count = '0;

      if (fire) begin
         if (is_end) begin
            push_job.masked       = hit_any;
            push_job.report_count = RCNT_W'(active);
            push                  = (len_ff != '0) || (active != '0);
            len_in                = '0;
            ovf_in                = 1'b0;
            for (int i = 0; i < MAX_WORDS; i++) begin
               cnt_in[i] = '0;
            end
         end else if (is_space) begin
            push_job.masked   = hit_any;
            push_job.has_char = 1'b1;
            push              = 1'b1;
            len_in            = '0;
            ovf_in            = 1'b0;
            cnt_in            = cnt_bump;
         end else if (ovf_ff) begin
            // Rest of an overlong word passes straight through.
            push_job.len      = '0;
            push_job.has_char = 1'b1;
            push              = 1'b1;
         end else if (len_ff == LEN_W'(MAX_WORD_LEN)) begin
            // Buffer is full: release it unchanged along with this byte.
            push_job.has_char = 1'b1;
            push              = 1'b1;
            len_in            = '0;
            ovf_in            = 1'b1;
         end else begin
            store_in[len_ff[BSEL_W-1:0]] = req_if.msg_byte;
            len_in = len_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
         for (int i = 0; i < MAX_WORDS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ design/wwcf_queue.sv @@
module wwcf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wwcf_pkg::job_type   push_job,
   input  logic                pop,
   output wwcf_pkg::job_type   head,
   output wwcf_pkg::qstat_type qstat
);
   import wwcf_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign head        = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/wwcf_back.sv @@
module wwcf_back (
   input  logic                clock,
   input  logic                reset,
   input  wwcf_pkg::qstat_type qstat,
   input  wwcf_pkg::job_type   head,
   output logic                pop,
   wwcf_rsp_if.source          rsp_if
);
   import wwcf_pkg::*;

   logic [SEQ_W-1:0]  k_ff, k_in;
   logic              valid_ff, valid_in;
   logic              kind_ff, kind_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [HIT_W-1:0]  hit_ff, hit_in;
   logic              last_ff, last_in;

   logic              advance;
   logic              emit;
   logic [TOT_W-1:0]  total;
   logic [TOT_W-1:0]  kk;
   logic [TOT_W-1:0]  rel;
   logic [SEL_W-1:0]  rep_sel;

   assign advance = !valid_ff || rsp_if.ready;
   assign emit    = !qstat.empty && advance;
   assign total   = TOT_W'(head.len) + TOT_W'(head.has_char) + TOT_W'(head.report_count);
   assign kk      = TOT_W'(k_ff);
   assign rel     = kk - TOT_W'(head.len) - TOT_W'(head.has_char);
   assign rep_sel = rel[SEL_W-1:0];

   // Result number k of the head job: word bytes, then the tail, then reports.
   always_comb begin
      kind_in = KIND_CHAR;
      byte_in = '0;
      idx_in  = '0;
      hit_in  = '0;
      if (kk < TOT_W'(head.len)) begin
         byte_in = head.masked ? CH_STAR : head.word[k_ff[BSEL_W-1:0]];
      end else if (head.has_char && (kk == TOT_W'(head.len))) begin
         byte_in = head.tail_byte;
      end else begin
         kind_in = KIND_REPORT;
         idx_in  = IDX_W'(rep_sel);
         hit_in  = head.counts[rep_sel];
      end
      last_in = ((kk + TOT_W'(1)) == total);
   end

   always_comb begin
      pop      = emit && last_in;
      valid_in = advance ? !qstat.empty : valid_ff;
      k_in     = k_ff;
      if (emit) begin
         k_in = last_in ? '0 : k_ff + SEQ_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         idx_ff  <= idx_in;
         hit_ff  <= hit_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         k_ff     <= k_in;
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.kind       = kind_ff;
   assign rsp_if.out_byte   = byte_ff;
   assign rsp_if.word_index = idx_ff;
   assign rsp_if.hit_count  = hit_ff;
   assign rsp_if.last       = last_ff;

endmodule

@@ design/whole_word_censor_filter.sv @@
// A letter is buffered and gives no result; each result of a space, end-of-message or
// pass-through byte goes through the job queue and then the back's output register before rsp offers it.
// Throughput: one req transaction per cycle while the two-entry job queue has room;
// the back emits one rsp transaction per cycle while rsp is ready, one job at a time.
// Reset (synchronous, active high) clears configuration, hit counters, word length,
// the job queue and the output valid; the word buffer bytes are left as they are.
module whole_word_censor_filter (
   input  logic       clock,
   input  logic       reset,
   wwcf_req_if.sink   req_if,
   wwcf_rsp_if.source rsp_if,
   wwcf_csr_if.sink   csr_if
);
   import wwcf_pkg::*;

   // Configuration registers. Writes are always taken; the block is
   // expected to be idle while they change.
   cfg_type cfg_ff, cfg_in;

   // Job handoff between the front and the back.
   logic      q_push;
   job_type   push_job;
   logic      q_pop;
   job_type   q_head;
   qstat_type qstat;

   logic               csr_fire;
   logic [CSR_IDX_W-1:0] banned_rel;

   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid && csr_if.ready;
   assign banned_rel   = csr_if.reg_index - CSR_BANNED_BASE;

   // Index zero sets the number of active words; the following indexes
   // each load one banned word. Indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         if (csr_if.reg_index == CSR_WORDS_IN_USE) begin
            cfg_in.words_in_use = csr_if.wdata[WIU_W-1:0];
         end else if ((csr_if.reg_index >= CSR_BANNED_BASE) &&
                      (int'(banned_rel) < MAX_WORDS)) begin
            cfg_in.banned[banned_rel[SEL_W-1:0]] = csr_if.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front buffers the current word, compares it at a word boundary,
   // keeps the hit counters and turns every transaction that yields output
   // into one job.
   wwcf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .cfg      (cfg_ff),
      .qstat    (qstat),
      .push     (q_push),
      .push_job (push_job)
   );

   // A short queue lets the front keep taking bytes while the back drains
   // a long job.
   wwcf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head     (q_head),
      .qstat    (qstat)
   );

   // The back walks each job one result per cycle into the output register while the
   // consumer takes them, and holds while a stalled consumer leaves that register full.
   wwcf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .qstat  (qstat),
      .head   (q_head),
      .pop    (q_pop),
      .rsp_if (rsp_if)
   );

`ifndef SYNTHESIS
   // The front must never hand a job to a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && qstat.full))
      else $error("job pushed into a full queue");

   // A job never describes more bytes or reports than the block holds.
   a_job_bounds: assert property (@(posedge clock) disable iff (reset)
      q_push |-> ((int'(push_job.len) <= MAX_WORD_LEN) &&
                  (int'(push_job.report_count) <= MAX_WORDS)))
      else $error("job exceeds word buffer or counter count");

   // The back pops only a job that is present.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !qstat.empty)
      else $error("pop from an empty queue");

   // After reset nothing is pending and no result is offered.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_if.valid && qstat.empty))
      else $error("state left over after reset");
`endif

endmodule
